// ----- sv/assert_macros.svh -----
// Assertion macros used by the regulator top level.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ----- sv/pidrc_pkg.sv -----
// Shared widths, register indices, reset values and stage types for the PID regulator.
// No dependencies; used by every pidrc module and the top level.
package pidrc_pkg;

	localparam int GAIN_W      = 20;
	localparam int LIMIT_W     = 16;
	localparam int IN_W        = 16;
	localparam int ERR_W       = IN_W + 1;
	localparam int STATE_W     = 18;
	localparam int ACC_W       = STATE_W + 1;
	localparam int PROD_P_W    = GAIN_W + ERR_W;
	localparam int PROD_W      = GAIN_W + ACC_W;
	localparam int SUM_W       = PROD_W + 2;
	localparam int OUT_W       = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = GAIN_W;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int SHIFT_W     = SUM_W - GAIN_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;

	localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 20'sd3072;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 20'sd246;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 20'sd0;
	localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 16'd2000;
	localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST   = 16'd3000;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic signed [GAIN_W-1:0] p;
		logic signed [GAIN_W-1:0] i;
		logic signed [GAIN_W-1:0] d;
	} gains_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] integral_limit;
		logic [LIMIT_W-1:0] output_limit;
	} limits_t;

	typedef struct packed {
		logic                   command;
		logic signed [IN_W-1:0] setpoint;
		logic signed [IN_W-1:0] measured;
	} in_word_t;

	typedef struct packed {
		logic                    command;
		logic signed [ERR_W-1:0] err;
		logic signed [ACC_W-1:0] integral;
		logic signed [ACC_W-1:0] diff;
	} err_word_t;

	typedef struct packed {
		logic                       command;
		logic signed [PROD_P_W-1:0] prod_p;
		logic signed [PROD_W-1:0]   prod_i;
		logic signed [PROD_W-1:0]   prod_d;
	} prod_word_t;

endpackage

// ----- sv/pidrc_state.sv -----
// Error stage: forms error, running integral and error difference, and owns the history.
// Depends on pidrc_pkg.
module pidrc_state (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_in,
	output logic                                 ready_in,
	input  pidrc_pkg::in_word_t                  word_in,
	input  logic [pidrc_pkg::LIMIT_W-1:0]        integral_limit,
	output logic                                 valid_out,
	input  logic                                 ready_out,
	output pidrc_pkg::err_word_t                 word_out
);

	logic                                  v_s2;
	pidrc_pkg::err_word_t                  word_s2;
	logic signed [pidrc_pkg::STATE_W-1:0]  integral_q;
	logic signed [pidrc_pkg::STATE_W-1:0]  prev_err_q;
	logic signed [pidrc_pkg::IN_W-1:0]     sp;
	logic signed [pidrc_pkg::IN_W-1:0]     meas;
	logic signed [pidrc_pkg::ERR_W-1:0]    err;
	logic signed [pidrc_pkg::ACC_W-1:0]    int_pre;
	logic signed [pidrc_pkg::ACC_W-1:0]    diff;
	logic signed [pidrc_pkg::ACC_W-1:0]    lim;
	logic signed [pidrc_pkg::ACC_W-1:0]    int_clamped;
	logic                                  adv;
	logic                                  take;

	assign adv      = !v_s2 || ready_out;
	assign ready_in = adv;
	assign take     = adv && valid_in;

	assign sp   = word_in.setpoint;
	assign meas = word_in.measured;

	always_comb begin
		err     = pidrc_pkg::ERR_W'(sp) - pidrc_pkg::ERR_W'(meas);
		int_pre = pidrc_pkg::ACC_W'(integral_q) + pidrc_pkg::ACC_W'(err);
		diff    = pidrc_pkg::ACC_W'(err) - pidrc_pkg::ACC_W'(prev_err_q);
		lim     = pidrc_pkg::ACC_W'({1'b0, integral_limit});
		// clamp only when the magnitude strictly exceeds the bound
		if (int_pre > lim) begin
			int_clamped = lim;
		end else if (int_pre < -lim) begin
			int_clamped = -lim;
		end else begin
			int_clamped = int_pre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2       <= 1'b0;
			integral_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (adv) begin
				v_s2 <= valid_in;
			end
			if (take) begin
				if (word_in.command == pidrc_pkg::CMD_CLEAR) begin
					integral_q <= '0;
					prev_err_q <= '0;
				end else begin
					integral_q <= pidrc_pkg::STATE_W'(int_clamped);
					prev_err_q <= pidrc_pkg::STATE_W'(err);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s2.command  <= word_in.command;
			word_s2.err      <= err;
			word_s2.integral <= int_pre;
			word_s2.diff     <= diff;
		end
	end

	assign valid_out = v_s2;
	assign word_out  = word_s2;

endmodule

// ----- sv/pidrc_mult.sv -----
// Product stage: three gain multiplies in parallel, registered.
// Depends on pidrc_pkg.
module pidrc_mult (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_in,
	output logic                  ready_in,
	input  pidrc_pkg::err_word_t  word_in,
	input  pidrc_pkg::gains_t     gains,
	output logic                  valid_out,
	input  logic                  ready_out,
	output pidrc_pkg::prod_word_t word_out
);

	logic                                   v_s3;
	pidrc_pkg::prod_word_t                  word_s3;
	logic signed [pidrc_pkg::GAIN_W-1:0]    kp;
	logic signed [pidrc_pkg::GAIN_W-1:0]    ki;
	logic signed [pidrc_pkg::GAIN_W-1:0]    kd;
	logic signed [pidrc_pkg::ERR_W-1:0]     err;
	logic signed [pidrc_pkg::ACC_W-1:0]     integral;
	logic signed [pidrc_pkg::ACC_W-1:0]     diff;
	logic signed [pidrc_pkg::PROD_P_W-1:0]  prod_p;
	logic signed [pidrc_pkg::PROD_W-1:0]    prod_i;
	logic signed [pidrc_pkg::PROD_W-1:0]    prod_d;
	logic                                   adv;

	assign adv      = !v_s3 || ready_out;
	assign ready_in = adv;

	assign kp       = gains.p;
	assign ki       = gains.i;
	assign kd       = gains.d;
	assign err      = word_in.err;
	assign integral = word_in.integral;
	assign diff     = word_in.diff;

	assign prod_p = pidrc_pkg::PROD_P_W'(kp) * pidrc_pkg::PROD_P_W'(err);
	assign prod_i = pidrc_pkg::PROD_W'(ki) * pidrc_pkg::PROD_W'(integral);
	assign prod_d = pidrc_pkg::PROD_W'(kd) * pidrc_pkg::PROD_W'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			word_s3.command <= word_in.command;
			word_s3.prod_p  <= prod_p;
			word_s3.prod_i  <= prod_i;
			word_s3.prod_d  <= prod_d;
		end
	end

	assign valid_out = v_s3;
	assign word_out  = word_s3;

endmodule

// ----- sv/pidrc_sat.sv -----
// Output stage: sums the products, floors off the fraction bits, saturates, holds the result.
// Depends on pidrc_pkg.
module pidrc_sat (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_in,
	output logic                                ready_in,
	input  pidrc_pkg::prod_word_t               word_in,
	input  logic [pidrc_pkg::LIMIT_W-1:0]       output_limit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pidrc_pkg::OUT_W-1:0]  control_output
);

	logic                                    v_q;
	logic signed [pidrc_pkg::OUT_W-1:0]      result_q;
	logic signed [pidrc_pkg::PROD_P_W-1:0]   prod_p;
	logic signed [pidrc_pkg::PROD_W-1:0]     prod_i;
	logic signed [pidrc_pkg::PROD_W-1:0]     prod_d;
	logic signed [pidrc_pkg::SUM_W-1:0]      sum;
	logic signed [pidrc_pkg::SHIFT_W-1:0]    shifted;
	logic signed [pidrc_pkg::SHIFT_W-1:0]    lim;
	logic signed [pidrc_pkg::SHIFT_W-1:0]    clamped;
	logic signed [pidrc_pkg::OUT_W-1:0]      result;
	logic                                    adv;

	assign adv      = !v_q || out_ready;
	assign ready_in = adv;

	assign prod_p = word_in.prod_p;
	assign prod_i = word_in.prod_i;
	assign prod_d = word_in.prod_d;

	always_comb begin
		sum = pidrc_pkg::SUM_W'(prod_p) + pidrc_pkg::SUM_W'(prod_i)
			+ pidrc_pkg::SUM_W'(prod_d);
		// dropping the low bits of a two's complement value rounds towards minus infinity
		shifted = sum[pidrc_pkg::SUM_W-1:pidrc_pkg::GAIN_FRAC_BITS];
		lim     = pidrc_pkg::SHIFT_W'({1'b0, output_limit});
		if (shifted > lim) begin
			clamped = lim;
		end else if (shifted < -lim) begin
			clamped = -lim;
		end else begin
			clamped = shifted;
		end
		if (word_in.command == pidrc_pkg::CMD_CLEAR) begin
			result = '0;
		end else begin
			result = clamped[pidrc_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_in) begin
			result_q <= result;
		end
	end

	assign out_valid      = v_q;
	assign control_output = result_q;

endmodule

// ----- sv/pid_regulator_with_clamps.sv -----
// Positional PID regulator with output and integral clamps: top level.
// Depends on pidrc_pkg, pidrc_state, pidrc_mult, pidrc_sat and assert_macros.svh.
//
// Usage:
//   Input words (command, setpoint, measured) enter on in_valid/in_ready; one
//   result word (control_output) leaves on out_valid/out_ready for every input.
//   A command of one clears the integral and previous error and returns zero.
//   Gains and limits are written through cfg_write/cfg_index/cfg_data; the user must do
//   so only while no word is in flight, unchecked by the block; indices beyond the register list are ignored.
// Timing:
//   Four register stages: input, error/integral, products, result. A word
//   passes through them in order and its result is offered from the last.
//   One word is accepted every cycle while the output is not held; the integral
//   recurrence closes within the error stage, so consecutive words see each other's history without waiting.
// Reset:
//   arst_n empties the pipeline, zeroes the history and loads the default
//   gains and limits.
// Back-pressure:
//   Each stage advances when the one after it is empty or moving, so bubbles
//   are squeezed out; with the output held, up to four words are buffered
//   before in_ready drops.
`include "assert_macros.svh"

module pid_regulator_with_clamps (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     command,
	input  logic signed [pidrc_pkg::IN_W-1:0]        setpoint,
	input  logic signed [pidrc_pkg::IN_W-1:0]        measured,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [pidrc_pkg::OUT_W-1:0]       control_output,
	input  logic                                     cfg_write,
	input  logic [pidrc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pidrc_pkg::CFG_DATA_W-1:0]         cfg_data
);

	pidrc_pkg::gains_t      gains_q;
	pidrc_pkg::limits_t     limits_q;
	logic                   v_s1;
	pidrc_pkg::in_word_t    word_s1;
	logic                   adv_s1;
	logic                   st_ready;
	logic                   v_s2;
	pidrc_pkg::err_word_t   word_s2;
	logic                   mult_ready;
	logic                   v_s3;
	pidrc_pkg::prod_word_t  word_s3;
	logic                   sat_ready;
	logic signed [pidrc_pkg::OUT_W:0] out_lim;
	logic                   out_in_range;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.p               <= pidrc_pkg::GAIN_P_RST;
			gains_q.i               <= pidrc_pkg::GAIN_I_RST;
			gains_q.d               <= pidrc_pkg::GAIN_D_RST;
			limits_q.integral_limit <= pidrc_pkg::INTEGRAL_LIMIT_RST;
			limits_q.output_limit   <= pidrc_pkg::OUTPUT_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pidrc_pkg::REG_GAIN_P: begin
					gains_q.p <= cfg_data[pidrc_pkg::GAIN_W-1:0];
				end
				pidrc_pkg::REG_GAIN_I: begin
					gains_q.i <= cfg_data[pidrc_pkg::GAIN_W-1:0];
				end
				pidrc_pkg::REG_GAIN_D: begin
					gains_q.d <= cfg_data[pidrc_pkg::GAIN_W-1:0];
				end
				pidrc_pkg::REG_INTEGRAL_LIMIT: begin
					limits_q.integral_limit <= cfg_data[pidrc_pkg::LIMIT_W-1:0];
				end
				pidrc_pkg::REG_OUTPUT_LIMIT: begin
					limits_q.output_limit <= cfg_data[pidrc_pkg::LIMIT_W-1:0];
				end
				default: begin
					// drop writes to unused indices
				end
			endcase
		end
	end

	// input register
	assign adv_s1   = !v_s1 || st_ready;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1.command  <= command;
			word_s1.setpoint <= setpoint;
			word_s1.measured <= measured;
		end
	end

	pidrc_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_in       (v_s1),
		.ready_in       (st_ready),
		.word_in        (word_s1),
		.integral_limit (limits_q.integral_limit),
		.valid_out      (v_s2),
		.ready_out      (mult_ready),
		.word_out       (word_s2)
	);

	pidrc_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (v_s2),
		.ready_in  (mult_ready),
		.word_in   (word_s2),
		.gains     (gains_q),
		.valid_out (v_s3),
		.ready_out (sat_ready),
		.word_out  (word_s3)
	);

	pidrc_sat u_sat (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_in       (v_s3),
		.ready_in       (sat_ready),
		.word_in        (word_s3),
		.output_limit   (limits_q.output_limit),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.control_output (control_output)
	);

	assign out_lim = (pidrc_pkg::OUT_W + 1)'({1'b0, limits_q.output_limit});
	assign out_in_range = (control_output <= out_lim) && (control_output >= -out_lim);

	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, v_s1)
	`ASSERT_IMPLY(a_out_within_limit, clk, arst_n, out_valid, out_in_range)
	`ASSERT_IMPLY(a_out_from_s3, clk, arst_n, $rose(out_valid), $past(v_s3))

endmodule
